>>> src/lrubc_pkg.sv
// Package for the LRU block buffer cache core.
// Holds the request and result transaction types and the function and status codes.
// No dependencies.
package lrubc_pkg;

    // Request kinds
    localparam logic [2:0] FN_GET     = 3'd0;
    localparam logic [2:0] FN_RELEASE = 3'd1;
    localparam logic [2:0] FN_PIN     = 3'd2;
    localparam logic [2:0] FN_UNPIN   = 3'd3;
    localparam logic [2:0] FN_WRITE   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Reference count limits
    localparam logic [7:0] REFS_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot;
    } t_in;

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       read_needed;
        logic       write_needed;
        logic [1:0] status;
    } t_out;

endpackage

>>> src/lru_block_buffer_cache_core.sv
// LRU block buffer cache core: buffer slot table with reference counts and recency order.
// Depends on lrubc_pkg (transaction types, function and status codes).
//
// Usage:
//   Request channel: i_in_valid / i_in_data / o_in_stall. A transaction is taken on a
//   clock edge with i_in_valid high and o_in_stall low. Result channel: o_out_valid /
//   o_out_data / i_out_stall, exactly one result per request, in request order.
//   One request is processed at a time; o_in_stall stays high from acceptance until the
//   result has been moved into the output register.
//   Each step runs through a single recency-memory read port and a single entry-memory
//   read port. A get first searches the recency order from the most recent end for a
//   matching tag; on a miss it then searches from the least recent end for a free slot,
//   also when no slot is free. A release of a slot that is not at the front shifts the
//   earlier positions back by one and writes the slot to the front. Pin, unpin and
//   write update the entry in place; a bad slot or unknown function goes straight to
//   the result.
//   Reset (i_rst_n low, synchronous) empties the table at once: all slots read as
//   device 0, block 0, count 0, invalid, clean, and the recency order is ascending.
//   No clearing pass is needed. When the receiver stalls, the result is held in the
//   output register; a finished request then waits before releasing the request channel.
module lru_block_buffer_cache_core
    import lrubc_pkg::*;
#(
    parameter int NUM_BUFFERS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  logic i_out_stall
);

    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST_IX = IW'(NUM_BUFFERS - 1);
    localparam logic [CW-1:0] NUM_C   = CW'(NUM_BUFFERS);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RMW   = 4'd1;
    localparam logic [3:0] S_HSCAN = 4'd2;
    localparam logic [3:0] S_MSCAN = 4'd3;
    localparam logic [3:0] S_FSCAN = 4'd4;
    localparam logic [3:0] S_SHRD  = 4'd5;
    localparam logic [3:0] S_SHWR  = 4'd6;
    localparam logic [3:0] S_FRONT = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic [7:0]  refs;
    } t_ent;

    // Control registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_iss, n_iss;
    logic          r_p1, n_p1;
    logic          r_p2, n_p2;
    logic [IW-1:0] r_c2, n_c2;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_j, n_j;
    logic          r_out_valid;
    t_in           r_req, n_req;
    t_out          r_res, n_res;
    t_out          r_out;

    // Memories and their per-entry written bits
    logic [IW-1:0]          r_rec_mem [NUM_BUFFERS];
    t_ent                   r_ent_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_rec_vld;
    logic [NUM_BUFFERS-1:0] r_ent_vld;
    logic [NUM_BUFFERS-1:0] r_valid;
    logic [NUM_BUFFERS-1:0] r_dirty;

    logic [IW-1:0] r_rec_q, r_rec_aq;
    logic          r_rec_iq;
    t_ent          r_ent_q;
    logic          r_ent_iq;

    // Port controls
    logic [IW-1:0] rec_raddr, rec_waddr, rec_wdata;
    logic          rec_we;
    logic [IW-1:0] ent_raddr, ent_waddr;
    t_ent          ent_wdata;
    logic          ent_we;
    logic [IW-1:0] flag_ix;
    logic          valid_set, dirty_set, dirty_clr;

    logic          in_acc;
    logic [IW-1:0] rec_eff;
    t_ent          ent_eff;
    logic [IW-1:0] s_ix;
    logic          load_out;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Unwritten entries read as their reset values
    assign rec_eff  = r_rec_iq ? r_rec_q : r_rec_aq;
    assign ent_eff  = r_ent_iq ? r_ent_q : '0;
    assign s_ix     = IW'(r_req.slot);
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_iss     = r_iss;
        n_p1      = 1'b0;
        n_p2      = 1'b0;
        n_c2      = r_c2;
        n_pos     = r_pos;
        n_j       = r_j;
        n_req     = r_req;
        n_res     = r_res;
        rec_raddr = '0;
        rec_waddr = '0;
        rec_wdata = '0;
        rec_we    = 1'b0;
        ent_raddr = '0;
        ent_waddr = '0;
        ent_wdata = ent_eff;
        ent_we    = 1'b0;
        flag_ix   = '0;
        valid_set = 1'b0;
        dirty_set = 1'b0;
        dirty_clr = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req = i_in_data;
                    n_res = '0;
                    n_iss = '0;
                    n_pos = '0;
                    if (i_in_data.func == FN_GET) begin
                        n_state = S_HSCAN;
                    end else if (i_in_data.func > FN_WRITE) begin
                        n_state = S_DONE;
                    end else if ({27'd0, i_in_data.slot} >= 32'(NUM_BUFFERS)) begin
                        n_res.slot_out = i_in_data.slot;
                        n_res.status   = ST_RANGE;
                        n_state        = S_DONE;
                    end else begin
                        ent_raddr = IW'(i_in_data.slot);
                        n_state   = S_RMW;
                    end
                end
            end

            // Count update for release, pin and unpin; dirty marking for write
            S_RMW: begin
                n_res.slot_out = r_req.slot;
                ent_waddr      = s_ix;
                n_state        = S_DONE;
                case (r_req.func)
                    FN_RELEASE, FN_UNPIN: begin
                        if (ent_eff.refs == '0) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            ent_wdata.refs = ent_eff.refs - 8'd1;
                            ent_we         = 1'b1;
                        end
                        if (r_req.func == FN_RELEASE) begin
                            n_state = S_FSCAN;
                        end
                    end
                    FN_PIN: begin
                        if (ent_eff.refs == REFS_MAX) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            ent_wdata.refs = ent_eff.refs + 8'd1;
                            ent_we         = 1'b1;
                        end
                    end
                    FN_WRITE: begin
                        dirty_set          = 1'b1;
                        flag_ix            = s_ix;
                        n_res.write_needed = 1'b1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Most-to-least recent search for a matching tag
            S_HSCAN: begin
                if (r_iss < NUM_C) begin
                    rec_raddr = r_iss[IW-1:0];
                    n_iss     = r_iss + 1'b1;
                    n_p1      = 1'b1;
                end
                if (r_p1) begin
                    ent_raddr = rec_eff;
                    n_c2      = rec_eff;
                    n_p2      = 1'b1;
                end
                if (r_p2) begin
                    if (ent_eff.device == r_req.device && ent_eff.block == r_req.block_number) begin
                        if (ent_eff.refs == REFS_MAX) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            ent_wdata.refs = ent_eff.refs + 8'd1;
                            ent_we         = 1'b1;
                        end
                        ent_waddr         = r_c2;
                        valid_set         = 1'b1;
                        flag_ix           = r_c2;
                        n_res.slot_out    = 5'(r_c2);
                        n_res.hit         = 1'b1;
                        n_res.read_needed = !r_valid[r_c2];
                        n_state           = S_DONE;
                    end else if (r_pos == LAST_IX) begin
                        n_iss   = '0;
                        n_pos   = '0;
                        n_p1    = 1'b0;
                        n_p2    = 1'b0;
                        n_state = S_MSCAN;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            // Least-to-most recent search for a free slot
            S_MSCAN: begin
                if (r_iss < NUM_C) begin
                    rec_raddr = LAST_IX - r_iss[IW-1:0];
                    n_iss     = r_iss + 1'b1;
                    n_p1      = 1'b1;
                end
                if (r_p1) begin
                    ent_raddr = rec_eff;
                    n_c2      = rec_eff;
                    n_p2      = 1'b1;
                end
                if (r_p2) begin
                    if (ent_eff.refs == '0) begin
                        ent_we            = 1'b1;
                        ent_waddr         = r_c2;
                        ent_wdata.device  = r_req.device;
                        ent_wdata.block   = r_req.block_number;
                        ent_wdata.refs    = 8'd1;
                        valid_set         = 1'b1;
                        dirty_clr         = 1'b1;
                        flag_ix           = r_c2;
                        n_res.slot_out    = 5'(r_c2);
                        n_res.read_needed = 1'b1;
                        n_state           = S_DONE;
                    end else if (r_pos == LAST_IX) begin
                        n_res.status = ST_NOFREE;
                        n_state      = S_DONE;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            // Find the recency position of the released slot
            S_FSCAN: begin
                if (r_iss < NUM_C) begin
                    rec_raddr = r_iss[IW-1:0];
                    n_iss     = r_iss + 1'b1;
                    n_p1      = 1'b1;
                end
                if (r_p1) begin
                    if (rec_eff == s_ix) begin
                        n_p1 = 1'b0;
                        if (r_pos == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_j     = r_pos;
                            n_state = S_SHRD;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            // Shift earlier positions back by one
            S_SHRD: begin
                rec_raddr = r_j - 1'b1;
                n_state   = S_SHWR;
            end

            S_SHWR: begin
                rec_we    = 1'b1;
                rec_waddr = r_j;
                rec_wdata = rec_eff;
                if (r_j == IW'(1)) begin
                    n_state = S_FRONT;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = S_SHRD;
                end
            end

            S_FRONT: begin
                rec_we    = 1'b1;
                rec_waddr = '0;
                rec_wdata = s_ix;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_rec_vld   <= '0;
            r_ent_vld   <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
        end else begin
            r_state <= n_state;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (rec_we) begin
                r_rec_vld[rec_waddr] <= 1'b1;
            end
            if (ent_we) begin
                r_ent_vld[ent_waddr] <= 1'b1;
            end
            if (valid_set) begin
                r_valid[flag_ix] <= 1'b1;
            end
            if (dirty_set) begin
                r_dirty[flag_ix] <= 1'b1;
            end else if (dirty_clr) begin
                r_dirty[flag_ix] <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_iss <= n_iss;
        r_c2  <= n_c2;
        r_pos <= n_pos;
        r_j   <= n_j;
        r_req <= n_req;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    // Recency memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_waddr] <= rec_wdata;
        end
        r_rec_q  <= r_rec_mem[rec_raddr];
        r_rec_iq <= r_rec_vld[rec_raddr];
        r_rec_aq <= rec_raddr;
    end

    // Entry memory: tag and count, one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_q  <= r_ent_mem[ent_raddr];
        r_ent_iq <= r_ent_vld[ent_raddr];
    end

endmodule

>>> src/lrubc_chk.sv
// Port-level checker for the LRU block buffer cache core, with its bind statement.
// Depends on lrubc_pkg and binds into lru_block_buffer_cache_core.
module lrubc_chk
    import lrubc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input t_in  i_in_data,
    input logic o_in_stall,
    input logic o_out_valid,
    input t_out o_out_data,
    input logic i_out_stall
);

    // One request at a time: an accepted transaction closes the request channel
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request channel open right after acceptance");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_NOFREE ||
                         o_out_data.status == ST_RANGE))
        else $error("undefined status code");

    // Hit or read results come from a get, never with a write request or a full table
    a_get_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.hit || o_out_data.read_needed)) |->
        (!o_out_data.write_needed && o_out_data.status != ST_NOFREE))
        else $error("get flags mixed with write or no-free result");

    // A full-table miss reports slot 0 and no flags
    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_NOFREE) |->
        (o_out_data.slot_out == '0 && !o_out_data.hit && !o_out_data.read_needed))
        else $error("no-free result carries slot or flags");

endmodule

bind lru_block_buffer_cache_core lrubc_chk u_lrubc_chk (.*);
